// File: rtl/core/afr_pkg.sv
// shared types and constants of the addressed frame receiver
package afr_pkg;

  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] END_MARK   = 8'hBB;
  localparam logic [7:0] BOARD_ID_RESET = 8'h01;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_END   = 3'd6
  } phase_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_OUT  = 1'b1
  } back_state_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic [7:0]  length;
  } desc_t;

endpackage

// File: rtl/core/addressed_frame_receiver_top.sv
// top level of the addressed frame receiver
// Takes one received byte per cycle. Header, check and end bytes are never held
// back, except that the end byte of a frame waits while the frame queue
// (QueueDepth entries) is full; payload bytes wait while results of an earlier
// frame are still queued or being emitted, since both share one payload buffer
// of min(MaxPayload, 32) bytes. A frame's results leave from the buffer's
// registered read port at one per cycle when pop is held high, starting the
// cycle after the frame reaches the emitter. The buffer needs no clearing
// after reset; only entries written in the current frame are read.
module addressed_frame_receiver_top import afr_pkg::*; #(
  parameter int unsigned MaxPayload = 32,
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status_o,
  output logic [7:0] command_o,
  output logic [7:0] payload_length_o,
  output logic       has_payload_o,
  output logic [4:0] payload_index_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  localparam int unsigned Cap   = (MaxPayload > 32) ? 32 : MaxPayload;
  localparam int unsigned AddrW = (Cap > 1) ? $clog2(Cap) : 1;

  desc_t            f_desc, q_desc;
  logic             f_push, q_full, q_valid, b_pop, b_busy, back_busy;
  logic             buf_we;
  logic [AddrW-1:0] buf_waddr;
  logic [7:0]       buf_wdata;

  assign back_busy = b_busy || q_valid;

  afr_front #(.Cap(Cap), .AddrW(AddrW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .back_busy_i (back_busy),
    .q_full_i    (q_full),
    .desc_push_o (f_push),
    .desc_o      (f_desc),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata)
  );

  afr_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_desc),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (q_desc),
    .valid_o (q_valid)
  );

  afr_back #(.Cap(Cap), .AddrW(AddrW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .buf_we_i         (buf_we),
    .buf_waddr_i      (buf_waddr),
    .buf_wdata_i      (buf_wdata),
    .desc_valid_i     (q_valid),
    .desc_i           (q_desc),
    .desc_pop_o       (b_pop),
    .busy_o           (b_busy),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .has_payload_o    (has_payload_o),
    .payload_index_o  (payload_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_o           (last_o)
  );

endmodule

// File: rtl/core/afr_front.sv
// frame parser: hunts, checks the address, fills the payload buffer, classifies the frame
module afr_front import afr_pkg::*; #(
  parameter int unsigned Cap   = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       rx_byte_i,
  input  logic             back_busy_i,
  input  logic             q_full_i,
  output logic             desc_push_o,
  output desc_t            desc_o,
  output logic             buf_we_o,
  output logic [AddrW-1:0] buf_waddr_o,
  output logic [7:0]       buf_wdata_o
);

  localparam logic [7:0] CapB = 8'(Cap);

  phase_e     phase_q, phase_d;
  logic [7:0] board_id_q;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] taken_q, taken_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] check_q, check_d;
  logic       accept;

  assign full   = ((phase_q == PH_DATA) && back_busy_i) || ((phase_q == PH_END) && q_full_i);
  assign accept = push && !full;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    taken_d     = taken_q;
    xor_d       = xor_q;
    check_d     = check_q;
    desc_push_o = 1'b0;
    buf_we_o    = 1'b0;
    buf_waddr_o = taken_q[AddrW-1:0];
    buf_wdata_o = rx_byte_i;
    desc_o.command = cmd_q;
    desc_o.length  = len_q;
    if (len_q > CapB) begin
      desc_o.status = ST_LONG;
    end else if ((rx_byte_i != END_MARK) || (check_q != xor_q)) begin
      desc_o.status = ST_BAD;
    end else begin
      desc_o.status = ST_OK;
    end
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_MARK) begin
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (rx_byte_i == board_id_q) begin
            xor_d   = rx_byte_i;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          taken_d = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          buf_we_o = (taken_q < CapB);
          xor_d    = xor_q ^ rx_byte_i;
          taken_d  = taken_q + 8'd1;
          if (({1'b0, taken_q} + 9'd1) >= {1'b0, len_q}) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          check_d = rx_byte_i;
          phase_d = PH_END;
        end
        PH_END: begin
          desc_push_o = 1'b1;
          phase_d     = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      board_id_q <= BOARD_ID_RESET;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) begin
        board_id_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    len_q   <= len_d;
    taken_q <= taken_d;
    xor_q   <= xor_d;
    check_q <= check_d;
  end

endmodule

// File: rtl/core/afr_fifo.sv
// short queue of classified frames between parser and result emitter
module afr_fifo import afr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t data_o,
  output logic  valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/afr_back.sv
// result emitter: payload buffer and result register
module afr_back import afr_pkg::*; #(
  parameter int unsigned Cap   = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             buf_we_i,
  input  logic [AddrW-1:0] buf_waddr_i,
  input  logic [7:0]       buf_wdata_i,
  input  logic             desc_valid_i,
  input  desc_t            desc_i,
  output logic             desc_pop_o,
  output logic             busy_o,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status_o,
  output logic [7:0]       command_o,
  output logic [7:0]       payload_length_o,
  output logic             has_payload_o,
  output logic [4:0]       payload_index_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o
);

  logic [7:0] mem [Cap];
  logic [7:0] rd_data_q;
  logic       rd_en;
  logic [4:0] rd_idx;

  back_state_e state_q, state_d;
  status_e     status_q, status_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_q, len_d;
  logic        has_q, has_d;
  logic [4:0]  idx_q, idx_d;
  logic        last_q, last_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    has_d      = has_q;
    idx_d      = idx_q;
    last_d     = last_q;
    desc_pop_o = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = idx_q + 5'd1;
    case (state_q)
      B_IDLE: begin
        if (desc_valid_i) begin
          desc_pop_o = 1'b1;
          status_d   = desc_i.status;
          cmd_d      = desc_i.command;
          len_d      = desc_i.length;
          idx_d      = 5'd0;
          state_d    = B_OUT;
          if ((desc_i.status == ST_OK) && (desc_i.length != 8'd0)) begin
            rd_en  = 1'b1;
            rd_idx = 5'd0;
            has_d  = 1'b1;
            last_d = (desc_i.length == 8'd1);
          end else begin
            has_d  = 1'b0;
            last_d = 1'b1;
          end
        end
      end
      B_OUT: begin
        if (pop) begin
          if (last_q) begin
            state_d = B_IDLE;
          end else begin
            rd_en  = 1'b1;
            idx_d  = idx_q + 5'd1;
            last_d = (({3'b000, idx_q} + 8'd2) == len_q);
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cmd_q    <= cmd_d;
    len_q    <= len_d;
    has_q    <= has_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (buf_we_i) begin
      mem[buf_waddr_i] <= buf_wdata_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_idx[AddrW-1:0]];
    end
  end

  assign busy_o           = (state_q != B_IDLE);
  assign empty            = (state_q != B_OUT);
  assign status_o         = status_q;
  assign command_o        = cmd_q;
  assign payload_length_o = len_q;
  assign has_payload_o    = has_q;
  assign payload_index_o  = idx_q;
  assign payload_byte_o   = has_q ? rd_data_q : 8'd0;
  assign last_o           = last_q;

endmodule

// File: rtl/core/afr_checker.sv
// port-level checks of the addressed frame receiver and their binding
module afr_checker import afr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status_o,
  input logic [7:0] command_o,
  input logic [7:0] payload_length_o,
  input logic       has_payload_o,
  input logic [4:0] payload_index_o,
  input logic [7:0] payload_byte_o,
  input logic       last_o
);

  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(payload_byte_o) && $stable(payload_index_o)
      && $stable(last_o)))
    else $error("result changed while waiting");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_payload_o) |-> (status_o == ST_OK))
    else $error("payload result on a bad frame");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_payload_o) |-> (last_o && (payload_index_o == 5'd0)
      && (payload_byte_o == 8'd0)))
    else $error("malformed single result");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_payload_o) |-> (last_o == (({3'b000, payload_index_o} + 8'd1)
      == payload_length_o)))
    else $error("last flag out of place");

  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && has_payload_o && !last_o) |=>
      (payload_index_o == ($past(payload_index_o) + 5'd1)) && $stable(command_o))
    else $error("payload index skipped");

endmodule

bind addressed_frame_receiver_top afr_checker u_afr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .status_o         (status_o),
  .command_o        (command_o),
  .payload_length_o (payload_length_o),
  .has_payload_o    (has_payload_o),
  .payload_index_o  (payload_index_o),
  .payload_byte_o   (payload_byte_o),
  .last_o           (last_o)
);
